// ===== rtl/lrc_pkg.sv =====
// Package for the load record checker: result record, error codes, header
// constants and the 24-bit end-around-carry adder. No dependencies.
package lrc_pkg;

   localparam int unsigned HDR_BYTES = 12;
   localparam int unsigned WORD_BITS = 24;
   localparam int unsigned ROM_BITS  = 25;
   localparam int unsigned OUT_ADDR_BITS = 48;

   localparam logic [ROM_BITS-1:0] IMAGE_WORDS_RESET = 25'd1024;
   localparam logic [3:0] HDR_LAST_POS = 4'(HDR_BYTES - 1);
   localparam logic [3:0] HDR_ADDR_POS = 4'd6;

   localparam logic CMD_DATA = 1'b0;
   localparam logic CMD_END  = 1'b1;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_RANGE = 2'd1,
      ERR_CSUM  = 2'd2,
      ERR_TRUNC = 2'd3
   } err_type;

   typedef struct packed {
      logic                      write_valid;
      logic [OUT_ADDR_BITS-1:0]  write_address;
      logic [WORD_BITS-1:0]      write_word;
      logic                      record_end;
      logic                      stream_end;
      err_type                   error_code;
      logic                      halted;
      logic [OUT_ADDR_BITS-1:0]  highest_address;
   } rsp_type;

   function automatic logic [WORD_BITS-1:0] add24(input logic [WORD_BITS-1:0] a,
                                                 input logic [WORD_BITS-1:0] b);
      logic [WORD_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[WORD_BITS-1:0] + {{(WORD_BITS-1){1'b0}}, s[WORD_BITS]};
   endfunction

endpackage

// ===== rtl/lrc_core.sv =====
// Record parser and checksum state for the load record checker.
// Computes one result per accepted byte from the current state.
// Depends on lrc_pkg.
module lrc_core #(
   parameter int LOCATION_BITS = 48
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic                              command,
   input  logic [7:0]                        byte_in,
   input  logic [lrc_pkg::ROM_BITS-1:0]      image_words,
   output lrc_pkg::rsp_type                  result
);

   localparam int EW = LOCATION_BITS + 1;

   typedef enum logic {
      PH_HEADER,
      PH_DATA
   } phase_type;

   phase_type                          phase_ff, phase_in;
   logic [3:0]                         pos_ff, pos_in;
   logic [lrc_pkg::WORD_BITS-1:0]      count_ff, count_in;
   logic [lrc_pkg::WORD_BITS-1:0]      csum_ff, csum_in;
   logic [LOCATION_BITS-1:0]           addr_ff, addr_in;
   logic [lrc_pkg::WORD_BITS-1:0]      left_ff, left_in;
   logic [15:0]                        part_ff, part_in;
   logic [lrc_pkg::WORD_BITS-1:0]      sum_ff, sum_in;
   logic [LOCATION_BITS-1:0]           high_ff, high_in;
   logic                               stopped_ff, stopped_in;

   logic [LOCATION_BITS-1:0]           hdr_addr;
   logic [lrc_pkg::OUT_ADDR_BITS-1:0]  hdr_addr48;
   logic [EW-1:0]                      hdr_end;
   logic [EW-1:0]                      hdr_last;
   logic [lrc_pkg::WORD_BITS-1:0]      hdr_sum;
   logic [lrc_pkg::WORD_BITS-1:0]      word;
   logic [lrc_pkg::WORD_BITS-1:0]      word_sum;
   logic [lrc_pkg::WORD_BITS-1:0]      left_dec;

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      csum_in    = csum_ff;
      addr_in    = addr_ff;
      left_in    = left_ff;
      part_in    = part_ff;
      sum_in     = sum_ff;
      high_in    = high_ff;
      stopped_in = stopped_ff;
      result     = '0;

      hdr_addr   = (pos_ff == lrc_pkg::HDR_ADDR_POS) ? LOCATION_BITS'(byte_in)
                                                     : {addr_ff[LOCATION_BITS-9:0], byte_in};
      hdr_addr48 = lrc_pkg::OUT_ADDR_BITS'(hdr_addr);
      hdr_end    = EW'(hdr_addr) + EW'(count_ff);
      hdr_last   = hdr_end - EW'(1);
      hdr_sum    = lrc_pkg::add24(lrc_pkg::add24(count_ff, hdr_addr48[23:0]),
                                  hdr_addr48[47:24]);
      word       = {part_ff, byte_in};
      word_sum   = lrc_pkg::add24(sum_ff, word);
      left_dec   = left_ff - 24'd1;

      if (accept && !stopped_ff) begin
         if (command == lrc_pkg::CMD_END) begin
            if (phase_ff == PH_HEADER && pos_ff == 4'd0) begin
               result.stream_end = 1'b1;
            end else begin
               result.error_code = lrc_pkg::ERR_TRUNC;
            end
            stopped_in = 1'b1;
         end else if (phase_ff == PH_HEADER) begin
            case (pos_ff) inside
               [4'd0:4'd2]: begin
                  count_in = (pos_ff == 4'd0) ? {16'h0, byte_in} : {count_ff[15:0], byte_in};
               end
               [4'd3:4'd5]: begin
                  csum_in = (pos_ff == 4'd3) ? {16'h0, byte_in} : {csum_ff[15:0], byte_in};
               end
               default: begin
                  addr_in = hdr_addr;
               end
            endcase
            pos_in = pos_ff + 4'd1;
            if (pos_ff == lrc_pkg::HDR_LAST_POS) begin
               pos_in = 4'd0;
               if (hdr_end > EW'(image_words)) begin
                  result.error_code = lrc_pkg::ERR_RANGE;
                  stopped_in        = 1'b1;
               end else begin
                  if ((count_ff != '0 || hdr_addr != '0) && hdr_last > EW'(high_ff)) begin
                     high_in = hdr_last[LOCATION_BITS-1:0];
                  end
                  sum_in  = hdr_sum;
                  left_in = count_ff;
                  if (count_ff == '0) begin
                     if (~hdr_sum == csum_ff) begin
                        result.record_end = 1'b1;
                     end else begin
                        result.error_code = lrc_pkg::ERR_CSUM;
                        stopped_in        = 1'b1;
                     end
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
            end
         end else begin
            case (pos_ff)
               4'd0: begin
                  part_in = {8'h0, byte_in};
                  pos_in  = 4'd1;
               end
               4'd1: begin
                  part_in = {part_ff[7:0], byte_in};
                  pos_in  = 4'd2;
               end
               default: begin
                  result.write_valid   = 1'b1;
                  result.write_address = lrc_pkg::OUT_ADDR_BITS'(addr_ff);
                  result.write_word    = word;
                  sum_in  = word_sum;
                  addr_in = addr_ff + LOCATION_BITS'(1);
                  left_in = left_dec;
                  pos_in  = 4'd0;
                  if (left_dec == '0) begin
                     phase_in = PH_HEADER;
                     if (~word_sum == csum_ff) begin
                        result.record_end = 1'b1;
                     end else begin
                        result.error_code = lrc_pkg::ERR_CSUM;
                        stopped_in        = 1'b1;
                     end
                  end
               end
            endcase
         end
      end

      result.halted          = stopped_in;
      result.highest_address = lrc_pkg::OUT_ADDR_BITS'(high_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         pos_ff     <= '0;
         count_ff   <= '0;
         csum_ff    <= '0;
         addr_ff    <= '0;
         left_ff    <= '0;
         part_ff    <= '0;
         sum_ff     <= '0;
         high_ff    <= '0;
         stopped_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         count_ff   <= count_in;
         csum_ff    <= csum_in;
         addr_ff    <= addr_in;
         left_ff    <= left_in;
         part_ff    <= part_in;
         sum_ff     <= sum_in;
         high_ff    <= high_in;
         stopped_ff <= stopped_in;
      end
   end

   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("halt released");

   a_data_pos: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> pos_ff <= 4'd2)
      else $error("byte position out of word range");

   a_hdr_pos: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= lrc_pkg::HDR_LAST_POS)
      else $error("byte position out of header range");

   a_write_err: assert property (@(posedge clock) disable iff (reset)
      result.write_valid |->
         (result.error_code == lrc_pkg::ERR_NONE || result.error_code == lrc_pkg::ERR_CSUM))
      else $error("write reported with range or truncation error");

   a_err_halts: assert property (@(posedge clock) disable iff (reset)
      accept && result.error_code != lrc_pkg::ERR_NONE |=> stopped_ff)
      else $error("error did not halt");

endmodule

// ===== rtl/load_record_checker.sv =====
// Top level of the load record checker: stream ports, image size register
// and result register. Depends on lrc_pkg and lrc_core.
//
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  tuser: command, tdata: byte_in
//  rsp      out  rsp_tvalid/rsp_tready  tuser: write_valid, tlast: record_end, tdata: rest
//  csr      in   csr_we                 csr_wdata: image_words
//
// One byte per cycle while req_tready is high; its result shows in the next cycle.
// The only loop is the record state update, with up to two chained 24-bit end-around adds.
// req_tready drops only while a result is held and rsp_tready is low.
// Synchronous reset clears the record state and sets image_words to 1024.
module load_record_checker #(
   parameter int LOCATION_BITS = 48
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,    // [7:0] byte_in
   input  logic          req_tuser,    // [0] command
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [127:0]  rsp_tdata,    // [47:0] write_address, [71:48] write_word,
                                       // [72] stream_end, [74:73] error_code,
                                       // [75] halted, [123:76] highest_address
   output logic          rsp_tuser,    // [0] write_valid
   output logic          rsp_tlast,    // record_end
   input  logic          csr_we,
   input  logic [24:0]   csr_wdata     // image_words
);

   logic                            accept;
   logic [lrc_pkg::ROM_BITS-1:0]    rom_ff;
   lrc_pkg::rsp_type                result;
   lrc_pkg::rsp_type                rsp_ff;
   logic                            rsp_valid_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   lrc_core #(
      .LOCATION_BITS (LOCATION_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .command     (req_tuser),
      .byte_in     (req_tdata),
      .image_words (rom_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_ff       <= lrc_pkg::IMAGE_WORDS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            rom_ff <= csr_wdata;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.write_valid;
   assign rsp_tlast  = rsp_ff.record_end;
   assign rsp_tdata  = {4'b0, rsp_ff.highest_address, rsp_ff.halted, rsp_ff.error_code,
                        rsp_ff.stream_end, rsp_ff.write_word, rsp_ff.write_address};

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for load_record_checker: feeds loader images of framed records,
// predicts every result with its own scoreboard model and compares per field.
// Depends on lrc_pkg and the load_record_checker RTL.

typedef enum bit {PH_HEADER, PH_DATA} record_phase_type;

function automatic bit [23:0] fold_sum(bit [63:0] s);
   while (s[63:24] != '0)
      s = {40'd0, s[23:0]} + (s >> 24);
   return s[23:0];
endfunction

class load_scoreboard;
   lrc_pkg::rsp_type  expected_q[$];
   int unsigned       fails;
   bit [24:0]         image_words;
   record_phase_type  phase;
   bit [3:0]          pos;
   bit [23:0]         count;
   bit [23:0]         hdr_csum;
   bit [23:0]         words_left;
   bit [23:0]         run_sum;
   bit [15:0]         partial;
   bit [47:0]         cur_addr;
   bit [47:0]         high_mark;
   bit                stopped;

   function new();
      fails = 0;
      image_words = lrc_pkg::IMAGE_WORDS_RESET;
      phase = PH_HEADER;
      pos = '0;
      count = '0;
      hdr_csum = '0;
      words_left = '0;
      run_sum = '0;
      partial = '0;
      cur_addr = '0;
      high_mark = '0;
      stopped = 1'b0;
   endfunction

   function bit close_record();
      phase = PH_HEADER;
      pos = '0;
      if (~run_sum == hdr_csum)
         return 1'b1;
      stopped = 1'b1;
      return 1'b0;
   endfunction

   function void note_byte(logic cmd, bit [7:0] b);
      lrc_pkg::rsp_type  r;
      lrc_pkg::err_type  e;
      bit [63:0]         last;
      bit [23:0]         w;
      r = '0;
      e = lrc_pkg::ERR_NONE;
      if (!stopped) begin
         if (cmd == lrc_pkg::CMD_END) begin
            if (phase == PH_HEADER && pos == 0)
               r.stream_end = 1'b1;
            else
               e = lrc_pkg::ERR_TRUNC;
            stopped = 1'b1;
         end else if (phase == PH_HEADER) begin
            if (pos < 3)
               count = (pos == 0) ? {16'd0, b} : {count[15:0], b};
            else if (pos < lrc_pkg::HDR_ADDR_POS)
               hdr_csum = (pos == 3) ? {16'd0, b} : {hdr_csum[15:0], b};
            else
               cur_addr = (pos == lrc_pkg::HDR_ADDR_POS) ? {40'd0, b} : {cur_addr[39:0], b};
            if (pos != lrc_pkg::HDR_LAST_POS) begin
               pos = pos + 4'd1;
            end else begin
               pos = '0;
               if ({16'd0, cur_addr} + 64'(count) > 64'(image_words)) begin
                  e = lrc_pkg::ERR_RANGE;
                  stopped = 1'b1;
               end else begin
                  // empty record at zero leaves the mark alone
                  if (count != 0 || cur_addr != 0) begin
                     last = {16'd0, cur_addr} + 64'(count) - 64'd1;
                     if (last > {16'd0, high_mark})
                        high_mark = last[47:0];
                  end
                  run_sum = fold_sum(64'(count) + 64'(cur_addr[23:0]) + 64'(cur_addr[47:24]));
                  words_left = count;
                  if (count == 0) begin
                     if (close_record())
                        r.record_end = 1'b1;
                     else
                        e = lrc_pkg::ERR_CSUM;
                  end else begin
                     phase = PH_DATA;
                  end
               end
            end
         end else if (pos == 0) begin
            partial = {8'd0, b};
            pos = 4'd1;
         end else if (pos == 1) begin
            partial = {partial[7:0], b};
            pos = 4'd2;
         end else begin
            w = {partial, b};
            r.write_valid = 1'b1;
            r.write_address = cur_addr;
            r.write_word = w;
            run_sum = fold_sum(64'(run_sum) + 64'(w));
            cur_addr = cur_addr + 48'd1;
            words_left = words_left - 24'd1;
            pos = '0;
            if (words_left == 0) begin
               if (close_record())
                  r.record_end = 1'b1;
               else
                  e = lrc_pkg::ERR_CSUM;
            end
         end
      end
      r.error_code = e;
      r.halted = stopped;
      r.highest_address = high_mark;
      expected_q.push_back(r);
   endfunction

   function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         fails++;
      end
   endfunction

   function void check_result(lrc_pkg::rsp_type got);
      lrc_pkg::rsp_type want;
      if (expected_q.size() == 0) begin
         $error("result with no transaction pending: %h", got);
         fails++;
         return;
      end
      want = expected_q.pop_front();
      compare_field("write_valid", want.write_valid, got.write_valid);
      compare_field("write_address", want.write_address, got.write_address);
      compare_field("write_word", want.write_word, got.write_word);
      compare_field("record_end", want.record_end, got.record_end);
      compare_field("stream_end", want.stream_end, got.stream_end);
      compare_field("error_code", want.error_code, got.error_code);
      compare_field("halted", want.halted, got.halted);
      compare_field("highest_address", want.highest_address, got.highest_address);
   endfunction
endclass

module tb_top;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned PHASE_ITEMS = 135;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;
   logic         req_tuser = lrc_pkg::CMD_DATA;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b1;
   logic [127:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   logic         csr_we = 1'b0;
   logic [24:0]  csr_wdata = lrc_pkg::IMAGE_WORDS_RESET;

   load_scoreboard sb = new();
   bit [7:0]       image_q[$];
   int unsigned    tx_idle_pct = 0;
   int unsigned    rx_stall_pct = 0;
   int unsigned    items_sent = 0;
   int unsigned    cycle_count = 0;
   bit [24:0]      rom_setting[8];

   load_record_checker #(.LOCATION_BITS(48)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
   end

   always @(posedge clock) begin : rsp_monitor
      lrc_pkg::rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.write_valid = rsp_tuser;
         got.write_address = rsp_tdata[47:0];
         got.write_word = rsp_tdata[71:48];
         got.record_end = rsp_tlast;
         got.stream_end = rsp_tdata[72];
         got.error_code = lrc_pkg::err_type'(rsp_tdata[74:73]);
         got.halted = rsp_tdata[75];
         got.highest_address = rsp_tdata[123:76];
         sb.check_result(got);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // enter and leave at a falling edge; tvalid stays high for a following transaction
   task automatic send_item(input logic cmd, input bit [7:0] b);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= b;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_byte(cmd, b);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_image(input int unsigned n);
      repeat (n) send_item(lrc_pkg::CMD_DATA, image_q.pop_front());
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (sb.expected_q.size() != 0)
         @(negedge clock);
   endtask

   task automatic push_record(input bit [23:0] cnt, input bit [47:0] addr, input bit bad_csum);
      bit [23:0] sum;
      bit [23:0] w;
      bit [23:0] csum;
      bit [23:0] words[$];
      sum = fold_sum(64'(cnt) + 64'(addr[23:0]) + 64'(addr[47:24]));
      repeat (cnt) begin
         case ($urandom_range(0, 7))
            0: w = '0;
            1: w = '1;
            default: w = 24'($urandom);
         endcase
         words.push_back(w);
         sum = fold_sum(64'(sum) + 64'(w));
      end
      csum = ~sum;
      if (bad_csum)
         csum ^= 24'($urandom_range(1, 24'hFFFFFF));
      for (int i = 2; i >= 0; i--)
         image_q.push_back(cnt[8*i +: 8]);
      for (int i = 2; i >= 0; i--)
         image_q.push_back(csum[8*i +: 8]);
      for (int i = 5; i >= 0; i--)
         image_q.push_back(addr[8*i +: 8]);
      foreach (words[k])
         for (int i = 2; i >= 0; i--)
            image_q.push_back(words[k][8*i +: 8]);
   endtask

   initial begin
      int unsigned phase_start;
      int unsigned span;
      bit [23:0]   cnt;
      bit [47:0]   addr;
      rom_setting = '{25'd0, 25'd16777216, 25'($urandom_range(2, 16777215)), 25'd1,
                      25'd16777216, 25'($urandom_range(2, 64)), 25'd1024,
                      25'($urandom_range(2, 16777215))};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty record at zero, then one word ending exactly at the top of the image
      push_record(24'd0, 48'd0, 1'b0);
      push_record(24'd1, 48'(lrc_pkg::IMAGE_WORDS_RESET - 1), 1'b0);
      send_image(image_q.size());

      for (int ph = 0; ph < 8; ph++) begin
         drain();
         csr_we <= 1'b1;
         csr_wdata <= rom_setting[ph];
         @(negedge clock);
         csr_we <= 1'b0;
         sb.image_words = rom_setting[ph];
         tx_idle_pct = (ph % 4 == 1) ? 47 : (ph % 4 == 3) ? 24 : 0;
         rx_stall_pct = (ph % 4 == 2) ? 47 : (ph % 4 == 3) ? 24 : 0;
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            case ($urandom_range(0, 9))
               0: cnt = '0;
               9: cnt = 24'($urandom_range(7, 30));
               default: cnt = 24'($urandom_range(1, 6));
            endcase
            if (25'(cnt) > rom_setting[ph])
               cnt = rom_setting[ph][23:0];
            span = rom_setting[ph] - cnt;
            addr = ($urandom_range(0, 3) == 0) ? 48'(span) : 48'($urandom_range(0, span));
            push_record(cnt, addr, 1'b0);
            send_image(image_q.size());
         end
      end

      // close the stream one of four ways; the block stays halted afterwards
      cnt = (sb.image_words < 4) ? sb.image_words[23:0] : 24'($urandom_range(1, 4));
      addr = 48'($urandom_range(0, sb.image_words - cnt));
      case ($urandom_range(0, 3))
         0: ;
         1: begin
            push_record(cnt, addr, 1'b0);
            send_image($urandom_range(1, image_q.size() - 1));
            image_q.delete();
         end
         2: begin
            push_record(cnt, addr, 1'b1);
            send_image(image_q.size());
         end
         default: begin
            cnt = 24'($urandom_range(0, 20));
            if ($urandom_range(0, 1) == 0)
               addr = 48'(sb.image_words) + 48'd1;
            else
               addr = {16'($urandom_range(1, 65535)), 32'($urandom)};
            push_record(cnt, addr, 1'b0);
            send_image(image_q.size());
         end
      endcase
      send_item(lrc_pkg::CMD_END, 8'($urandom));
      repeat (12) send_item(1'($urandom_range(0, 1)), 8'($urandom));

      drain();
      repeat (4) @(negedge clock);
      if (sb.fails == 0 && sb.expected_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
